FILE: rtl/cpt_pkg.sv
// Shared constants for the correlation peak tracker.
// Used by correlation_peak_tracker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

  // Width of the row length register.
  localparam int CFG_BITS = 11;
  // Width of the shift result and of the output stream data.
  localparam int SHIFT_BITS = 11;
  localparam int OUT_TDATA_BITS = 16;
  // Defaults for the top level parameters.
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_SAMPLE_BITS = 16;
  // Row length after reset.
  localparam logic [CFG_BITS-1:0] RESET_ROW_LENGTH = 11'd1024;

endpackage

`default_nettype wire

FILE: rtl/cpt_decide.sv
// Side selection for the peak walk: registered cross products of gain and distance.
// Depends on nothing; instantiated by correlation_peak_tracker.
`timescale 1ns / 1ps
`default_nettype none

module cpt_decide #(
  parameter int SAMPLE_BITS = 16,
  parameter int POS_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic [SAMPLE_BITS:0]  gain_left,
  input  wire logic [SAMPLE_BITS:0]  gain_right,
  input  wire logic [POS_BITS-1:0]   dist_left,
  input  wire logic [POS_BITS-1:0]   dist_right,
  output logic                       take_left
);

  localparam int PW = SAMPLE_BITS + 1 + POS_BITS;

  logic [PW-1:0] prod_left;
  logic [PW-1:0] prod_right;

  // The left gain is weighed against the right distance and vice versa,
  // so the two ratios are compared without a divider.
  always_ff @(posedge clk) begin
    prod_left  <= PW'(gain_left) * PW'(dist_right);
    prod_right <= PW'(gain_right) * PW'(dist_left);
  end

  assign take_left = prod_left > prod_right;

endmodule

`default_nettype wire

FILE: rtl/correlation_peak_tracker.sv
// The first row after reset goes from its last sample straight to the finish step, which loads
// the result; later rows pass through the center read, center wait, left walk, right walk,
// multiply and finish steps, and the walk reads at most row length - 1 samples over the single
// read port of the row memory. A stalled result holds the finish step. Throughput: one sample
// per cycle while a row loads; after a row ends, no sample is taken until its result is loaded.
// Reset (synchronous, rst high): no previous row, row length 1024, empty row, output empty.
`timescale 1ns / 1ps
`default_nettype none

module correlation_peak_tracker #(
  parameter int MAX_COLUMNS = cpt_pkg::DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS = cpt_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Row length register write port.
  input  wire logic                                 cfg_we,
  input  wire logic [cpt_pkg::CFG_BITS-1:0]         cfg_data,
  // Sample stream. tdata: sample (SAMPLE_BITS, signed), zero padded to whole bytes.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Result stream. tdata: shift (bits 10:0, signed), zero padded to 16 bits.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [cpt_pkg::OUT_TDATA_BITS-1:0]        m_axis_tdata
);

  import cpt_pkg::*;

  // Position bits index the row memory; count bits also hold the row length itself.
  localparam int LB = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NB = LB + 1;
  localparam int CW = (NB > CFG_BITS) ? NB : CFG_BITS;
  localparam int XW = (NB > SHIFT_BITS) ? NB : SHIFT_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_LOAD,
    S_CENTER,
    S_CWAIT,
    S_LEFT,
    S_RIGHT,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration and per-row tracking state.
  logic [CFG_BITS-1:0]           row_length;
  logic [LB-1:0]                 count;
  logic [LB-1:0]                 last;
  logic signed [SAMPLE_BITS-1:0] row_min;
  logic signed [SAMPLE_BITS-1:0] best_val;
  logic [LB-1:0]                 best_pos;
  logic [LB-1:0]                 tracked;
  logic                          trk_valid;

  // Walk state. Reads are issued one per cycle and checked in the cycle after, so
  // pend marks a read whose data is in rd_data and pend_pos is its position.
  logic [LB-1:0]                 y;
  logic [LB-1:0]                 yl;
  logic [LB-1:0]                 yr;
  logic signed [SAMPLE_BITS-1:0] rl;
  logic signed [SAMPLE_BITS-1:0] rr;
  logic [LB-1:0]                 addr;
  logic                          more;
  logic                          pend;
  logic [LB-1:0]                 pend_pos;

  // Row memory with a registered read port.
  logic signed [SAMPLE_BITS-1:0] row_store [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          rd_en;
  logic [LB-1:0]                 rd_addr;

  // Output register.
  logic [SHIFT_BITS-1:0]         m_shift;

  // Datapath helpers.
  logic                          s_xfer;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [NB-1:0]                 n_cnt;
  logic [CW-1:0]                 len_x;
  logic [CW-1:0]                 eff_len;
  logic                          row_end;
  logic signed [SAMPLE_BITS-1:0] cur_peak;
  logic                          stop;
  logic                          walk_done;
  logic [SAMPLE_BITS:0]          gain_left;
  logic [SAMPLE_BITS:0]          gain_right;
  logic [LB-1:0]                 dist_left;
  logic [LB-1:0]                 dist_right;
  logic                          take_left;
  logic                          out_free;
  logic [LB-1:0]                 new_pos;
  logic [NB-1:0]                 row_n;
  logic [XW-1:0]                 shift_wide;

  assign s_axis_tready = (state == S_LOAD);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];

  // The row ends once the number of samples held reaches the effective length,
  // which is the register clamped to the range 2 .. MAX_COLUMNS.
  assign n_cnt   = NB'(count) + NB'(1);
  assign len_x   = CW'(row_length);
  assign eff_len = (len_x < CW'(2)) ? CW'(2) :
                   ((len_x > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : len_x);
  assign row_end = CW'(n_cnt) >= eff_len;

  // A walk direction stops at the first sample below the best value seen on that side.
  assign cur_peak  = (state == S_LEFT) ? rl : rr;
  assign stop      = pend && (rd_data < cur_peak);
  assign walk_done = stop || (!pend && !more);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr;
    case (state)
      S_CENTER: begin
        rd_en   = 1'b1;
        rd_addr = y;
      end
      S_LEFT, S_RIGHT: begin
        rd_en = more && !stop;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      row_store[count] <= sample;
    end
    if (rd_en) begin
      rd_data <= row_store[rd_addr];
    end
  end

  // Gains are measured from the row minimum; a zero distance counts as one.
  assign gain_left  = {rl[SAMPLE_BITS-1], rl} - {row_min[SAMPLE_BITS-1], row_min};
  assign gain_right = {rr[SAMPLE_BITS-1], rr} - {row_min[SAMPLE_BITS-1], row_min};
  assign dist_left  = (y == yl) ? LB'(1) : (y - yl);
  assign dist_right = (yr == y) ? LB'(1) : (yr - y);

  cpt_decide #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .POS_BITS   (LB)
  ) u_decide (
    .clk       (clk),
    .gain_left (gain_left),
    .gain_right(gain_right),
    .dist_left (dist_left),
    .dist_right(dist_right),
    .take_left (take_left)
  );

  // The first row after reset takes its first maximum; later rows take the walk
  // result, with ties going right.
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign new_pos    = !trk_valid ? best_pos : (take_left ? yl : yr);
  assign row_n      = NB'(last) + NB'(1);
  assign shift_wide = XW'(new_pos) - (XW'(row_n) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      row_length <= RESET_ROW_LENGTH;
      count      <= '0;
      last       <= '0;
      row_min    <= SMAX;
      best_val   <= SMIN;
      best_pos   <= '0;
      tracked    <= '0;
      trk_valid  <= 1'b0;
      more       <= 1'b0;
      pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_length <= cfg_data;
      end
      // The finish step sets the output valid itself when it loads a new result.
      if (m_axis_tvalid && m_axis_tready && (state != S_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (s_xfer) begin
            if (sample < row_min) begin
              row_min <= sample;
            end
            if (sample > best_val) begin
              best_val <= sample;
              best_pos <= count;
            end
            if (row_end) begin
              count <= '0;
              last  <= count;
              // A tracked position beyond this row starts from its last sample.
              y     <= (tracked > count) ? count : tracked;
              state <= trk_valid ? S_CENTER : S_FINISH;
            end else begin
              count <= n_cnt[LB-1:0];
            end
          end
        end

        S_CENTER: begin
          state <= S_CWAIT;
        end

        S_CWAIT: begin
          rl    <= rd_data;
          rr    <= rd_data;
          yl    <= y;
          yr    <= y;
          addr  <= y - LB'(1);
          more  <= (y != '0);
          pend  <= 1'b0;
          state <= S_LEFT;
        end

        S_LEFT: begin
          // Equal samples are crossed; only a strictly higher one moves the peak.
          if (pend && !stop && (rd_data > rl)) begin
            rl <= rd_data;
            yl <= pend_pos;
          end
          if (walk_done) begin
            pend  <= 1'b0;
            addr  <= y + LB'(1);
            more  <= (y < last);
            state <= S_RIGHT;
          end else begin
            pend     <= more;
            pend_pos <= addr;
            if (more) begin
              if (addr == '0) begin
                more <= 1'b0;
              end else begin
                addr <= addr - LB'(1);
              end
            end
          end
        end

        S_RIGHT: begin
          if (pend && !stop && (rd_data > rr)) begin
            rr <= rd_data;
            yr <= pend_pos;
          end
          if (walk_done) begin
            pend  <= 1'b0;
            more  <= 1'b0;
            state <= S_MUL;
          end else begin
            pend     <= more;
            pend_pos <= addr;
            if (more) begin
              if (addr == last) begin
                more <= 1'b0;
              end else begin
                addr <= addr + LB'(1);
              end
            end
          end
        end

        S_MUL: begin
          // The cross products register during this cycle.
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            tracked       <= new_pos;
            trk_valid     <= 1'b1;
            m_axis_tvalid <= 1'b1;
            m_shift       <= shift_wide[SHIFT_BITS-1:0];
            row_min       <= SMAX;
            best_val      <= SMIN;
            best_pos      <= '0;
            state         <= S_LOAD;
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_BITS-SHIFT_BITS){1'b0}}, m_shift};

`ifndef SYNTH
  // A sample that closes a row stops further sample transfers until the result is built.
  a_row_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && row_end) |=> !s_axis_tready)
    else $error("sample accepted right after the end of a row");

  // A new result is only ever loaded from the finishing step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_FINISH))
    else $error("result appeared outside the finishing step");

  // The walk keeps its left peak at or left of the start and its right peak at or right.
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEFT || state == S_RIGHT || state == S_MUL) |-> (yl <= y && yr >= y))
    else $error("walk peak on the wrong side of the start position");

  // Once a row has been tracked, the block never falls back to the first-row rule.
  a_tracking_holds: assert property (@(posedge clk) disable iff (rst)
    trk_valid |=> trk_valid)
    else $error("tracking state lost without reset");
`endif

endmodule

`default_nettype wire
